@@ design/rfla_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rfla_pkg;

   localparam int STACK_DEPTH = 32;
   localparam int LIST_DEPTH  = 32;
   localparam int MAX_OUT     = 32;

   localparam int SIDX_W = $clog2(STACK_DEPTH);
   localparam int SCNT_W = $clog2(STACK_DEPTH + 1);
   localparam int LIDX_W = $clog2(LIST_DEPTH);
   localparam int LCNT_W = $clog2(LIST_DEPTH + 1);

   localparam int RESET_FREE = 18;
   localparam int RESET_USED = 2;

   localparam logic [4:0] REG_T0 = 5'd8;
   localparam logic [4:0] REG_S7 = 5'd23;
   localparam logic [4:0] REG_FP = 5'd30;
   localparam logic [4:0] REG_RA = 5'd31;

   localparam logic [15:0] SLOT_BYTES = 16'd4;

   localparam logic [1:0] ACT_ALLOC      = 2'd0;
   localparam logic [1:0] ACT_RELEASE    = 2'd1;
   localparam logic [1:0] ACT_LIST_STORE = 2'd2;
   localparam logic [1:0] ACT_LIST_LOAD  = 2'd3;

   localparam logic [1:0] OP_ALLOC   = 2'd0;
   localparam logic [1:0] OP_RELEASE = 2'd1;
   localparam logic [1:0] OP_LIST    = 2'd2;

   localparam logic [2:0] STAT_OK         = 3'd0;
   localparam logic [2:0] STAT_OUT_OF_REG = 3'd1;
   localparam logic [2:0] STAT_NOT_IN_USE = 3'd2;
   localparam logic [2:0] STAT_STACK_FULL = 3'd3;
   localparam logic [2:0] STAT_LIST_EMPTY = 3'd4;

   typedef struct packed {
      logic [1:0]  op;
      logic        is_load;
      logic [4:0]  reg_num;
      logic [15:0] base;
   } rfla_cmd_type;

   // free stack after reset, bottom to top: s7..s0, t9, t8, t7..t0
   function automatic logic [4:0] stack_reset_val(input logic [SIDX_W-1:0] idx);
      logic [4:0] val;
      val = 5'd0;
      if (int'(idx) < 8) begin
         val = 5'(int'(REG_S7) - int'(idx));
      end else if (int'(idx) < 10) begin
         val = 5'(33 - int'(idx));
      end else if (int'(idx) < RESET_FREE) begin
         val = 5'(int'(REG_T0) + RESET_FREE - 1 - int'(idx));
      end
      return val;
   endfunction

   function automatic logic [4:0] list_reset_val(input logic [LIDX_W-1:0] idx);
      logic [4:0] val;
      val = 5'd0;
      if (int'(idx) == 0) begin
         val = REG_FP;
      end else if (int'(idx) == 1) begin
         val = REG_RA;
      end
      return val;
   endfunction

endpackage

`default_nettype wire

@@ design/rfla_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rfla_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [1:0]            req_action,
   input  wire logic [4:0]            req_reg_number,
   input  wire logic signed [15:0]    req_base_offset,
   output logic                       cmd_valid,
   input  wire logic                  cmd_ready,
   output rfla_pkg::rfla_cmd_type     cmd
);
   import rfla_pkg::*;

   rfla_cmd_type q_ff [2];
   logic         wptr_ff, wptr_in;
   logic         rptr_ff, rptr_in;
   logic [1:0]   cnt_ff, cnt_in;
   rfla_cmd_type decoded;
   logic         push, pop;

   // classify the transaction
   always_comb begin
      decoded.reg_num = req_reg_number;
      decoded.base    = req_base_offset;
      decoded.is_load = 1'b0;
      unique case (req_action)
         ACT_ALLOC:   decoded.op = OP_ALLOC;
         ACT_RELEASE: decoded.op = OP_RELEASE;
         ACT_LIST_STORE: decoded.op = OP_LIST;
         ACT_LIST_LOAD: begin
            decoded.op      = OP_LIST;
            decoded.is_load = 1'b1;
         end
         default: decoded.op = OP_LIST;
      endcase
   end

   assign req_ready = (cnt_ff != 2'd2);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = q_ff[rptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = cmd_valid && cmd_ready;

   always_comb begin
      wptr_in = push ? ~wptr_ff : wptr_ff;
      rptr_in = pop ? ~rptr_ff : rptr_ff;
      cnt_in  = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wptr_ff] <= decoded;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

`default_nettype wire

@@ design/rfla_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rfla_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  cmd_valid,
   output logic                       cmd_ready,
   input  wire rfla_pkg::rfla_cmd_type cmd,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [4:0]                 rsp_reg_out,
   output logic signed [15:0]         rsp_slot_offset,
   output logic                       rsp_is_load,
   output logic [7:0]                 rsp_used_bytes,
   output logic [2:0]                 rsp_status,
   output logic                       rsp_last
);
   import rfla_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_AREAD  = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_LIST   = 3'd3;
   localparam logic [2:0] S_RESULT = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [SCNT_W-1:0] fc_ff, fc_in;
   logic [LCNT_W-1:0] uc_ff, uc_in;
   logic [4:0]        cur_reg_ff, cur_reg_in;
   logic              cur_ld_ff, cur_ld_in;
   logic              full_ff, full_in;
   logic              found_ff, found_in;
   logic [LCNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic [LIDX_W-1:0] data_idx_ff, data_idx_in;
   logic [LIDX_W-1:0] wr_idx_ff, wr_idx_in;
   logic [LCNT_W-1:0] li_ff, li_in;
   logic [LCNT_W-1:0] n_ff, n_in;
   logic [15:0]       off_ff, off_in;
   logic [4:0]        res_reg_ff, res_reg_in;
   logic [2:0]        res_stat_ff, res_stat_in;

   logic              out_vld_ff, out_vld_in;
   logic [4:0]        out_reg_ff, out_reg_in;
   logic [15:0]       out_off_ff, out_off_in;
   logic              out_ld_ff, out_ld_in;
   logic [7:0]        out_bytes_ff, out_bytes_in;
   logic [2:0]        out_stat_ff, out_stat_in;
   logic              out_last_ff, out_last_in;

   // free stack memory
   logic [4:0]        stk_mem [STACK_DEPTH];
   logic [STACK_DEPTH-1:0] stk_vld_ff;
   logic [4:0]        stk_rd_ff;
   logic              stk_we, stk_re;
   logic [SIDX_W-1:0] stk_wa, stk_ra;
   logic [4:0]        stk_wd;

   // in-use list memory
   logic [4:0]        lst_mem [LIST_DEPTH];
   logic [LIST_DEPTH-1:0] lst_vld_ff;
   logic [4:0]        lst_rd_ff;
   logic              lst_we, lst_re;
   logic [LIDX_W-1:0] lst_wa, lst_ra;
   logic [4:0]        lst_wd;

   logic              out_free, out_load;
   logic [SCNT_W-1:0] fc_m1;
   logic [LCNT_W-1:0] li_nx;
   logic              match, found_now;

   assign out_free  = !out_vld_ff || rsp_ready;
   assign cmd_ready = (state_ff == S_IDLE);
   assign fc_m1     = fc_ff - 1'b1;
   assign li_nx     = li_ff + 1'b1;
   assign match     = (lst_rd_ff == cur_reg_ff);
   assign found_now = found_ff || match;

   always_comb begin
      state_in    = state_ff;
      fc_in       = fc_ff;
      uc_in       = uc_ff;
      cur_reg_in  = cur_reg_ff;
      cur_ld_in   = cur_ld_ff;
      full_in     = full_ff;
      found_in    = found_ff;
      rd_idx_in   = rd_idx_ff;
      data_idx_in = data_idx_ff;
      wr_idx_in   = wr_idx_ff;
      li_in       = li_ff;
      n_in        = n_ff;
      off_in      = off_ff;
      res_reg_in  = res_reg_ff;
      res_stat_in = res_stat_ff;
      stk_we      = 1'b0;
      stk_wa      = fc_ff[SIDX_W-1:0];
      stk_wd      = cmd.reg_num;
      stk_re      = 1'b0;
      stk_ra      = fc_m1[SIDX_W-1:0];
      lst_we      = 1'b0;
      lst_wa      = wr_idx_ff;
      lst_wd      = lst_rd_ff;
      lst_re      = 1'b0;
      lst_ra      = '0;
      out_load    = 1'b0;
      out_reg_in  = res_reg_ff;
      out_off_in  = 16'd0;
      out_ld_in   = 1'b0;
      out_stat_in = res_stat_ff;
      out_last_in = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cur_reg_in = cmd.reg_num;
               cur_ld_in  = cmd.is_load;
               unique case (cmd.op)
                  OP_ALLOC: begin
                     if (fc_ff == '0 || uc_ff >= LCNT_W'(LIST_DEPTH)) begin
                        res_reg_in  = 5'd0;
                        res_stat_in = STAT_OUT_OF_REG;
                        state_in    = S_RESULT;
                     end else begin
                        stk_re   = 1'b1;
                        state_in = S_AREAD;
                     end
                  end
                  OP_RELEASE: begin
                     res_reg_in = cmd.reg_num;
                     found_in   = 1'b0;
                     if (fc_ff >= SCNT_W'(STACK_DEPTH)) begin
                        full_in = 1'b1;
                     end else begin
                        full_in = 1'b0;
                        stk_we  = 1'b1;
                        fc_in   = fc_ff + 1'b1;
                     end
                     if (uc_ff == '0) begin
                        res_stat_in = (fc_ff >= SCNT_W'(STACK_DEPTH)) ?
                                      STAT_STACK_FULL : STAT_NOT_IN_USE;
                        state_in    = S_RESULT;
                     end else begin
                        lst_re      = 1'b1;
                        lst_ra      = '0;
                        data_idx_in = '0;
                        rd_idx_in   = LCNT_W'(1);
                        state_in    = S_SCAN;
                     end
                  end
                  OP_LIST: begin
                     if (uc_ff == '0) begin
                        res_reg_in  = 5'd0;
                        res_stat_in = STAT_LIST_EMPTY;
                        cur_ld_in   = 1'b0;
                        state_in    = S_RESULT;
                     end else begin
                        if (int'(uc_ff) > MAX_OUT) begin
                           n_in = LCNT_W'(MAX_OUT);
                        end else begin
                           n_in = uc_ff;
                        end
                        lst_re   = 1'b1;
                        lst_ra   = '0;
                        li_in    = '0;
                        off_in   = cmd.base;
                        state_in = S_LIST;
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_AREAD: begin
            lst_we      = 1'b1;
            lst_wa      = uc_ff[LIDX_W-1:0];
            lst_wd      = stk_rd_ff;
            fc_in       = fc_m1;
            uc_in       = uc_ff + 1'b1;
            res_reg_in  = stk_rd_ff;
            res_stat_in = STAT_OK;
            state_in    = S_RESULT;
         end
         S_SCAN: begin
            if (!found_ff && match) begin
               found_in  = 1'b1;
               wr_idx_in = data_idx_ff;
            end else if (found_ff) begin
               lst_we    = 1'b1;
               wr_idx_in = wr_idx_ff + 1'b1;
            end
            if (rd_idx_ff < uc_ff) begin
               lst_re      = 1'b1;
               lst_ra      = rd_idx_ff[LIDX_W-1:0];
               data_idx_in = rd_idx_ff[LIDX_W-1:0];
               rd_idx_in   = rd_idx_ff + 1'b1;
            end else begin
               if (found_now) begin
                  uc_in = uc_ff - 1'b1;
               end
               if (full_ff) begin
                  res_stat_in = STAT_STACK_FULL;
               end else if (found_now) begin
                  res_stat_in = STAT_OK;
               end else begin
                  res_stat_in = STAT_NOT_IN_USE;
               end
               state_in = S_RESULT;
            end
         end
         S_LIST: begin
            if (out_free) begin
               out_load    = 1'b1;
               out_reg_in  = lst_rd_ff;
               out_off_in  = off_ff;
               out_ld_in   = cur_ld_ff;
               out_stat_in = STAT_OK;
               out_last_in = (li_nx == n_ff);
               off_in      = off_ff + SLOT_BYTES;
               li_in       = li_nx;
               if (li_nx == n_ff) begin
                  state_in = S_IDLE;
               end else begin
                  lst_re = 1'b1;
                  lst_ra = li_nx[LIDX_W-1:0];
               end
            end
         end
         S_RESULT: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      out_bytes_in = 8'({uc_ff, 2'b00});
      out_vld_in   = out_vld_ff;
      if (out_load) begin
         out_vld_in = 1'b1;
      end else if (rsp_ready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[stk_wa] <= stk_wd;
      end
      if (stk_re) begin
         stk_rd_ff <= stk_vld_ff[stk_ra] ? stk_mem[stk_ra] : stack_reset_val(stk_ra);
      end
   end

   always_ff @(posedge clock) begin
      if (lst_we) begin
         lst_mem[lst_wa] <= lst_wd;
      end
      if (lst_re) begin
         lst_rd_ff <= lst_vld_ff[lst_ra] ? lst_mem[lst_ra] : list_reset_val(lst_ra);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stk_vld_ff <= '0;
         lst_vld_ff <= '0;
      end else begin
         if (stk_we) begin
            stk_vld_ff[stk_wa] <= 1'b1;
         end
         if (lst_we) begin
            lst_vld_ff[lst_wa] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         fc_ff      <= SCNT_W'(RESET_FREE);
         uc_ff      <= LCNT_W'(RESET_USED);
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         fc_ff      <= fc_in;
         uc_ff      <= uc_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_reg_ff  <= cur_reg_in;
      cur_ld_ff   <= cur_ld_in;
      full_ff     <= full_in;
      found_ff    <= found_in;
      rd_idx_ff   <= rd_idx_in;
      data_idx_ff <= data_idx_in;
      wr_idx_ff   <= wr_idx_in;
      li_ff       <= li_in;
      n_ff        <= n_in;
      off_ff      <= off_in;
      res_reg_ff  <= res_reg_in;
      res_stat_ff <= res_stat_in;
      if (out_load) begin
         out_reg_ff   <= out_reg_in;
         out_off_ff   <= out_off_in;
         out_ld_ff    <= out_ld_in;
         out_bytes_ff <= out_bytes_in;
         out_stat_ff  <= out_stat_in;
         out_last_ff  <= out_last_in;
      end
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_reg_out     = out_reg_ff;
   assign rsp_slot_offset = out_off_ff;
   assign rsp_is_load     = out_ld_ff;
   assign rsp_used_bytes  = out_bytes_ff;
   assign rsp_status      = out_stat_ff;
   assign rsp_last        = out_last_ff;

endmodule

`default_nettype wire

@@ design/register_free_list_allocator.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel  handshake            payload
// req      req_valid/req_ready  req_action, req_reg_number, req_base_offset
// rsp      rsp_valid/rsp_ready  rsp_reg_out, rsp_slot_offset, rsp_is_load,
//                               rsp_used_bytes, rsp_status, rsp_last
//
// a two-entry command queue takes transactions while the sequencer works
// allocate: stack read, list append, result load; release: a scan of the list
// list: one slot per cycle while rsp is not stalled, set by the single read port
// of the in-use list; release compaction is paced by the same port
// reset restores the free stack and in-use list at once via per-entry valid bits
// a stalled rsp holds the sequencer; req stalls only when the queue is full

module register_free_list_allocator (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_action,
   input  wire logic [4:0]         req_reg_number,
   input  wire logic signed [15:0] req_base_offset,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [4:0]              rsp_reg_out,
   output logic signed [15:0]      rsp_slot_offset,
   output logic                    rsp_is_load,
   output logic [7:0]              rsp_used_bytes,
   output logic [2:0]              rsp_status,
   output logic                    rsp_last
);
   import rfla_pkg::*;

   rfla_cmd_type cmd;
   logic         cmd_valid;
   logic         cmd_ready;

   rfla_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_reg_number  (req_reg_number),
      .req_base_offset (req_base_offset),
      .cmd_valid       (cmd_valid),
      .cmd_ready       (cmd_ready),
      .cmd             (cmd)
   );

   rfla_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (cmd_valid),
      .cmd_ready       (cmd_ready),
      .cmd             (cmd),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_reg_out     (rsp_reg_out),
      .rsp_slot_offset (rsp_slot_offset),
      .rsp_is_load     (rsp_is_load),
      .rsp_used_bytes  (rsp_used_bytes),
      .rsp_status      (rsp_status),
      .rsp_last        (rsp_last)
   );

endmodule

`default_nettype wire

@@ design/rfla_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rfla_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic [4:0]         rsp_reg_out,
   input wire logic signed [15:0] rsp_slot_offset,
   input wire logic               rsp_is_load,
   input wire logic [7:0]         rsp_used_bytes,
   input wire logic [2:0]         rsp_status,
   input wire logic               rsp_last
);
   import rfla_pkg::*;

   // stalled transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_reg_out)
         && $stable(rsp_slot_offset) && $stable(rsp_status) && $stable(rsp_last))
      else $error("rsp payload changed while stalled");

   a_bytes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_used_bytes[1:0] == 2'b00 && rsp_used_bytes <= 8'd128)
      else $error("used bytes not a multiple of four in range");

   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_OK |-> rsp_last && !rsp_is_load)
      else $error("error result not single");

   a_err_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_OK |-> rsp_slot_offset == 16'sd0)
      else $error("error result with nonzero offset");

   // consecutive list slots step by four
   a_slot_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last && rsp_status == STAT_OK ##1 rsp_valid
         |-> rsp_slot_offset == $past(rsp_slot_offset) + 16'sd4)
      else $error("list slot offset did not step by four");

endmodule

bind register_free_list_allocator rfla_checker u_rfla_checker (.*);

`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;
   import rfla_pkg::*;

   localparam int IDLE_LIMIT   = 4000;
   localparam int RANDOM_ITEMS = 110;
   localparam int TAIL_CYCLES  = 60;

   localparam logic [4:0] REG_T1 = 5'd9;
   localparam logic [4:0] REG_T8 = 5'd24;
   localparam logic [4:0] REG_T9 = 5'd25;

   typedef struct packed {
      logic [1:0]  action;
      logic [4:0]  regn;
      logic [15:0] base;
   } alloc_cmd_type;

   typedef struct packed {
      logic [4:0]  reg_out;
      logic [15:0] slot_offset;
      logic        is_load;
      logic [7:0]  used_bytes;
      logic [2:0]  status;
      logic        last;
   } alloc_rsp_type;

   typedef enum int {
      READY_ALWAYS,
      READY_RANDOM,
      READY_PERIODIC,
      READY_BURSTY
   } ready_mode_type;

   logic               clock           = 1'b0;
   logic               reset           = 1'b1;
   logic               req_valid       = 1'b0;
   logic               req_ready;
   logic [1:0]         req_action      = ACT_ALLOC;
   logic [4:0]         req_reg_number  = 5'd0;
   logic signed [15:0] req_base_offset = 16'sd0;
   logic               rsp_valid;
   logic               rsp_ready       = 1'b0;
   logic [4:0]         rsp_reg_out;
   logic signed [15:0] rsp_slot_offset;
   logic               rsp_is_load;
   logic [7:0]         rsp_used_bytes;
   logic [2:0]         rsp_status;
   logic               rsp_last;

   register_free_list_allocator u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_reg_number  (req_reg_number),
      .req_base_offset (req_base_offset),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_reg_out     (rsp_reg_out),
      .rsp_slot_offset (rsp_slot_offset),
      .rsp_is_load     (rsp_is_load),
      .rsp_used_bytes  (rsp_used_bytes),
      .rsp_status      (rsp_status),
      .rsp_last        (rsp_last)
   );

   always #5 clock = ~clock;

   // shadow of the free stack and the in-use list
   logic [4:0] free_regs [STACK_DEPTH];
   int         free_top;
   logic [4:0] live_regs [LIST_DEPTH];
   int         live_count;

   alloc_cmd_type todo_cmds [$];
   alloc_rsp_type owed_results [$];

   int errors      = 0;
   int idle_cycles = 0;
   int planned     = 0;

   task automatic reset_shadow();
      for (int i = 0; i < STACK_DEPTH; i++) free_regs[i] = 5'd0;
      for (int i = 0; i < LIST_DEPTH; i++) live_regs[i] = 5'd0;
      for (int i = 0; i < 8; i++) free_regs[i] = REG_S7 - 5'(i);
      free_regs[8] = REG_T9;
      free_regs[9] = REG_T8;
      for (int i = 10; i < RESET_FREE; i++) free_regs[i] = REG_T0 + 5'(RESET_FREE - 1 - i);
      free_top     = RESET_FREE;
      live_regs[0] = REG_FP;
      live_regs[1] = REG_RA;
      live_count   = RESET_USED;
   endtask

   task automatic owe(input logic [4:0] r, input logic [15:0] off, input logic ld,
                      input logic [2:0] st, input logic lst);
      alloc_rsp_type res;
      res.reg_out     = r;
      res.slot_offset = off;
      res.is_load     = ld;
      res.used_bytes  = 8'(live_count * 4);
      res.status      = st;
      res.last        = lst;
      owed_results.insert(owed_results.size(), res);
   endtask

   task automatic allocator_step(input alloc_cmd_type cmd);
      logic [2:0] st;
      bit         found;
      int         n;
      case (cmd.action)
         ACT_ALLOC: begin
            if (free_top == 0 || live_count >= LIST_DEPTH) begin
               owe(5'd0, 16'd0, 1'b0, STAT_OUT_OF_REG, 1'b1);
            end else begin
               free_top--;
               live_regs[live_count] = free_regs[free_top];
               live_count++;
               owe(free_regs[free_top], 16'd0, 1'b0, STAT_OK, 1'b1);
            end
         end
         ACT_RELEASE: begin
            st    = STAT_OK;
            found = 1'b0;
            if (free_top >= STACK_DEPTH) begin
               st = STAT_STACK_FULL;
            end else begin
               free_regs[free_top] = cmd.regn;
               free_top++;
            end
            for (int i = 0; i < live_count; i++) begin
               if (!found && live_regs[i] == cmd.regn) found = 1'b1;
               if (found && i + 1 < live_count) live_regs[i] = live_regs[i + 1];
            end
            if (found) begin
               live_count--;
               live_regs[live_count] = 5'd0;
            end else if (st == STAT_OK) begin
               st = STAT_NOT_IN_USE;
            end
            owe(cmd.regn, 16'd0, 1'b0, st, 1'b1);
         end
         default: begin
            n = (live_count > MAX_OUT) ? MAX_OUT : live_count;
            if (n == 0) begin
               owe(5'd0, 16'd0, 1'b0, STAT_LIST_EMPTY, 1'b1);
            end else begin
               for (int i = 0; i < n; i++) begin
                  owe(live_regs[i], cmd.base + 16'(i) * SLOT_BYTES,
                      cmd.action == ACT_LIST_LOAD, STAT_OK, i == n - 1);
               end
            end
         end
      endcase
   endtask

   // sender: bursts of random length separated by random gaps
   int burst_left = 0;
   int gap_left   = 0;

   always @(posedge clock) begin : drive_req
      alloc_cmd_type cmd;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (todo_cmds.size() > 0) begin
            cmd = todo_cmds.pop_front();
            req_action      <= cmd.action;
            req_reg_number  <= cmd.regn;
            req_base_offset <= cmd.base;
            req_valid       <= 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 12);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall pattern
   ready_mode_type ready_mode = READY_ALWAYS;
   int             mode_left  = 0;
   int             stall_left = 0;
   int             cyc        = 0;

   always @(posedge clock) begin : drive_ready
      cyc++;
      if (mode_left == 0) begin
         ready_mode = ready_mode_type'($urandom_range(0, 3));
         mode_left  = $urandom_range(40, 160);
      end else begin
         mode_left--;
      end
      case (ready_mode)
         READY_ALWAYS: begin
            rsp_ready <= 1'b1;
         end
         READY_RANDOM: begin
            rsp_ready <= ($urandom_range(0, 3) != 0);
         end
         READY_PERIODIC: begin
            rsp_ready <= ((cyc % 7) >= 3);
         end
         default: begin
            if (stall_left > 0) begin
               stall_left--;
               rsp_ready <= 1'b0;
            end else if ($urandom_range(0, 15) == 0) begin
               stall_left = $urandom_range(5, 20);
               rsp_ready <= 1'b0;
            end else begin
               rsp_ready <= 1'b1;
            end
         end
      endcase
   end

   task automatic flag_result(input alloc_rsp_type got, input alloc_rsp_type want,
                              input bit orphan);
      errors++;
      if (errors <= 10) begin
         if (orphan) begin
            $display("unexpected result: reg %0d off %h ld %0d bytes %0d st %0d last %0d",
                     got.reg_out, got.slot_offset, got.is_load, got.used_bytes,
                     got.status, got.last);
         end else begin
            $display("mismatch: got reg %0d off %h ld %0d bytes %0d st %0d last %0d",
                     got.reg_out, got.slot_offset, got.is_load, got.used_bytes,
                     got.status, got.last);
            $display("        want reg %0d off %h ld %0d bytes %0d st %0d last %0d",
                     want.reg_out, want.slot_offset, want.is_load, want.used_bytes,
                     want.status, want.last);
         end
      end
   endtask

   always @(posedge clock) begin : watch_channels
      alloc_cmd_type cmd;
      alloc_rsp_type got;
      alloc_rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            cmd.action = req_action;
            cmd.regn   = req_reg_number;
            cmd.base   = req_base_offset;
            allocator_step(cmd);
         end
         if (rsp_valid && rsp_ready) begin
            got.reg_out     = rsp_reg_out;
            got.slot_offset = rsp_slot_offset;
            got.is_load     = rsp_is_load;
            got.used_bytes  = rsp_used_bytes;
            got.status      = rsp_status;
            got.last        = rsp_last;
            if (owed_results.size() == 0) begin
               flag_result(got, got, 1'b1);
            end else begin
               want = owed_results.pop_front();
               if (got !== want) flag_result(got, want, 1'b0);
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
   end

   initial begin : watchdog
      wait (idle_cycles >= IDLE_LIMIT);
      $display("FAIL register_free_list_allocator");
      $finish;
   end

   task automatic send(input logic [1:0] a, input logic [4:0] r, input logic [15:0] b);
      alloc_cmd_type cmd;
      cmd.action = a;
      cmd.regn   = r;
      cmd.base   = b;
      todo_cmds.insert(todo_cmds.size(), cmd);
   endtask

   task automatic send_random(input logic [1:0] a, input logic [4:0] r);
      send(a, r, 16'($urandom));
      planned++;
   endtask

   task automatic wait_quiet();
      @(negedge clock);
      while (todo_cmds.size() != 0 || req_valid || owed_results.size() != 0) begin
         @(negedge clock);
      end
   endtask

   function automatic bit is_live(input logic [4:0] r);
      bit hit;
      hit = 1'b0;
      for (int i = 0; i < live_count; i++) begin
         if (live_regs[i] == r) hit = 1'b1;
      end
      return hit;
   endfunction

   function automatic logic [4:0] pick_unused();
      logic [4:0] r;
      r = 5'($urandom);
      for (int k = 0; k < 64 && is_live(r); k++) r = 5'($urandom);
      return r;
   endfunction

   task automatic plan_noise();
      int n;
      n = $urandom_range(8, 14);
      repeat (n) send_random(2'($urandom), 5'($urandom));
   endtask

   task automatic plan_alloc_run();
      int n;
      n = free_top;
      if (LIST_DEPTH - live_count < n) n = LIST_DEPTH - live_count;
      repeat (n + 1) send_random(ACT_ALLOC, 5'($urandom));
   endtask

   task automatic plan_stack_fill();
      repeat (STACK_DEPTH - free_top) send_random(ACT_RELEASE, pick_unused());
      if (live_count > 0) begin
         send_random(ACT_RELEASE, live_regs[$urandom_range(0, live_count - 1)]);
      end
      send_random(ACT_RELEASE, 5'($urandom));
   endtask

   task automatic plan_drain();
      logic [4:0] order [$];
      logic [4:0] tmp;
      int         j;
      for (int i = 0; i < live_count; i++) order.insert(order.size(), live_regs[i]);
      for (int i = order.size() - 1; i > 0; i--) begin
         j        = $urandom_range(0, i);
         tmp      = order[i];
         order[i] = order[j];
         order[j] = tmp;
      end
      foreach (order[i]) send_random(ACT_RELEASE, order[i]);
   endtask

   task automatic plan_lists();
      int n;
      n = $urandom_range(2, 3);
      repeat (n) begin
         send_random(($urandom_range(0, 1) == 0) ? ACT_LIST_STORE : ACT_LIST_LOAD,
                     5'($urandom));
      end
   endtask

   initial begin
      reset_shadow();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send(ACT_LIST_STORE, 5'd0, 16'h0000);
      send(ACT_LIST_LOAD, 5'd31, 16'h7FFC);
      send(ACT_LIST_STORE, 5'd31, 16'h8000);
      send(ACT_LIST_LOAD, 5'd0, 16'hFFFF);
      send(ACT_ALLOC, 5'd0, 16'h0000);
      send(ACT_ALLOC, 5'd31, 16'hFFFF);
      send(ACT_RELEASE, REG_T1, 16'h0000);
      send(ACT_RELEASE, REG_FP, 16'hFFFF);
      send(ACT_RELEASE, 5'd0, 16'h0000);
      send(ACT_RELEASE, REG_RA, 16'h0000);
      send(ACT_RELEASE, REG_T0, 16'h0000);
      // in-use list is empty now
      send(ACT_LIST_STORE, 5'd0, 16'h1234);
      send(ACT_LIST_LOAD, 5'd31, 16'hFFFF);
      send(ACT_ALLOC, 5'd0, 16'h0000);
      send(ACT_ALLOC, 5'd0, 16'h0000);
      send(ACT_RELEASE, 5'd31, 16'h5555);
      send(ACT_LIST_LOAD, 5'd0, 16'h7FFF);
      send(ACT_RELEASE, 5'd31, 16'hAAAA);
      send(ACT_LIST_STORE, 5'd31, 16'h8001);
      wait_quiet();

      // empty stack, stack full, full list, long lists, empty list
      plan_noise();
      wait_quiet();
      plan_alloc_run();
      wait_quiet();
      plan_stack_fill();
      wait_quiet();
      plan_alloc_run();
      wait_quiet();
      plan_lists();
      wait_quiet();
      plan_drain();
      wait_quiet();
      plan_lists();
      wait_quiet();

      while (planned < RANDOM_ITEMS) begin
         case ($urandom_range(0, 4))
            0: begin
               plan_noise();
            end
            1: begin
               plan_alloc_run();
            end
            2: begin
               plan_stack_fill();
            end
            3: begin
               plan_drain();
            end
            default: begin
               plan_lists();
            end
         endcase
         wait_quiet();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("PASS register_free_list_allocator");
      end else begin
         $display("FAIL register_free_list_allocator");
      end
      $finish;
   end

endmodule
